/* hw/rtl/mtt_pkg.sv */
// Shared types and constants for the min tournament tree block.
package mtt_pkg;

  localparam int CMD_W      = 2;
  localparam int LEAF_W     = 10;
  localparam int PORT_VAL_W = 32;
  localparam int LIVE_W     = 11;

  localparam logic [LIVE_W-1:0] LIVE_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RELAX = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF,
    ST_WALK,
    ST_RESP
  } state_t;

endpackage

/* hw/rtl/mtt_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module mtt_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/mtt_min_unit.sv */
// Shared min-select unit: the left operand wins only when strictly smaller.
module mtt_min_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic [VALUE_BITS-1:0]      left_val,
  input  logic [mtt_pkg::LEAF_W-1:0] left_who,
  input  logic [VALUE_BITS-1:0]      right_val,
  input  logic [mtt_pkg::LEAF_W-1:0] right_who,
  output logic [VALUE_BITS-1:0]      win_val,
  output logic [mtt_pkg::LEAF_W-1:0] win_who
);

  logic left_wins;

  assign left_wins = left_val < right_val;
  assign win_val   = left_wins ? left_val : right_val;
  assign win_who   = left_wins ? left_who : right_who;

endmodule

/* hw/rtl/min_tournament_tree_relax_close_core.sv */
// Min winner tree priority queue: load, relax and close leaves, report the root.
//
//   Channel   Ports                                                   Dir
//   request   in_valid in_stall in_cmd in_leaf in_value               in
//   result    out_valid out_stall out_top_value out_top_leaf          out
//             out_heap_empty out_closed_value
//
// A request that changes a leaf passes from accept through one leaf read, D
// path levels (D = depth of the leaf, 10 for 1024 leaves) and the response
// state. Each level uses the single tree RAM read port and the one shared
// min-select unit. An unused command or a leaf out of range goes straight to
// the response; a relax or close of a closed leaf stops after the leaf read.
// After reset all 2*LEAVES tree RAM nodes are swept to infinity; in_stall
// stays high meanwhile. in_stall is high from accept until the result is in
// the output register; a stalled result holds until taken.
module min_tournament_tree_relax_close_core #(
  parameter int LEAVES     = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mtt_pkg::CMD_W-1:0]      in_cmd,
  input  logic [mtt_pkg::LEAF_W-1:0]     in_leaf,
  input  logic [mtt_pkg::PORT_VAL_W-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mtt_pkg::PORT_VAL_W-1:0] out_top_value,
  output logic [mtt_pkg::LEAF_W-1:0]     out_top_leaf,
  output logic                           out_heap_empty,
  output logic [mtt_pkg::PORT_VAL_W-1:0] out_closed_value
);

  localparam int NODES = 2 * LEAVES;
  localparam int AW    = $clog2(NODES);
  localparam int LW    = mtt_pkg::LEAF_W;
  localparam int NW    = VALUE_BITS + LW + 1;
  localparam int PW    = mtt_pkg::PORT_VAL_W;

  localparam logic [VALUE_BITS-1:0] INF       = '1;
  localparam logic [AW-1:0]         LAST_ADDR = AW'(NODES - 1);
  localparam logic [AW-1:0]         LEAF_BASE = AW'(LEAVES);
  localparam logic [AW-1:0]         ROOT_ADDR = AW'(1);

  mtt_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]               clr_r, clr_nxt;
  logic [mtt_pkg::CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [LW-1:0]               leaf_r, leaf_nxt;
  logic [VALUE_BITS-1:0]       val_r, val_nxt;
  logic [VALUE_BITS-1:0]       cand_r, cand_nxt;
  logic [AW-1:0]               pos_r, pos_nxt;
  logic [VALUE_BITS-1:0]       cur_val_r, cur_val_nxt;
  logic [LW-1:0]               cur_who_r, cur_who_nxt;
  logic [VALUE_BITS-1:0]       root_val_r, root_val_nxt;
  logic [LW-1:0]               root_who_r, root_who_nxt;
  logic [VALUE_BITS-1:0]       last_closed_r, last_closed_nxt;
  logic [mtt_pkg::LIVE_W-1:0]  live_r, live_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [PW-1:0]               out_top_value_r, out_top_value_nxt;
  logic [LW-1:0]               out_top_leaf_r, out_top_leaf_nxt;
  logic                        out_heap_empty_r, out_heap_empty_nxt;
  logic [PW-1:0]               out_closed_value_r, out_closed_value_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [NW-1:0]               ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [NW-1:0]               ram_rdata;
  logic [VALUE_BITS-1:0]       rd_val;
  logic [LW-1:0]               rd_who;
  logic                        rd_mark;

  logic [VALUE_BITS-1:0]       left_val, right_val, win_val;
  logic [LW-1:0]               left_who, right_who, win_who;

  logic [63:0]                 in_value_ext;
  logic [VALUE_BITS-1:0]       in_v;
  logic [VALUE_BITS:0]         sum;
  logic [VALUE_BITS-1:0]       sum_sat;
  logic                        in_acc;
  logic                        in_act;
  logic [AW-1:0]               in_leaf_pos;
  logic [AW-1:0]               parent;
  logic                        leaf_changed;
  logic                        resp_load;
  logic [VALUE_BITS-1:0]       new_val;
  logic                        new_mark;
  logic [63:0]                 root_ext;
  logic [63:0]                 closed_ext;

  mtt_ram #(
    .WIDTH (NW),
    .DEPTH (NODES)
  ) u_tree_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mtt_min_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_min (
    .left_val  (left_val),
    .left_who  (left_who),
    .right_val (right_val),
    .right_who (right_who),
    .win_val   (win_val),
    .win_who   (win_who)
  );

  assign rd_val  = ram_rdata[VALUE_BITS-1:0];
  assign rd_who  = ram_rdata[VALUE_BITS+LW-1:VALUE_BITS];
  assign rd_mark = ram_rdata[NW-1];

  assign in_stall = (state_r != mtt_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Only the low VALUE_BITS of the request value count.
  assign in_value_ext = 64'(in_value);
  assign in_v         = in_value_ext[VALUE_BITS-1:0];
  assign in_leaf_pos  = LEAF_BASE + AW'(in_leaf);
  assign in_act       = (32'(in_leaf) < LEAVES) &&
                        (in_cmd == mtt_pkg::CMD_LOAD || in_cmd == mtt_pkg::CMD_RELAX ||
                         in_cmd == mtt_pkg::CMD_CLOSE);

  // Saturating relax candidate: infinity stays infinity.
  assign sum     = {1'b0, last_closed_r} + {1'b0, in_v};
  assign sum_sat = (last_closed_r == INF || in_v == INF || sum >= {1'b0, INF}) ?
                   INF : sum[VALUE_BITS-1:0];

  assign parent       = pos_r >> 1;
  assign leaf_changed = (cmd_r == mtt_pkg::CMD_LOAD) || !rd_mark;
  assign resp_load    = !out_valid_r || !out_stall;

  assign root_ext   = 64'(root_val_r);
  assign closed_ext = 64'(last_closed_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mtt_pkg::ST_CLEAR: begin
        if (clr_r == LAST_ADDR) begin
          state_nxt = mtt_pkg::ST_IDLE;
        end
      end
      mtt_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = in_act ? mtt_pkg::ST_LEAF : mtt_pkg::ST_RESP;
        end
      end
      mtt_pkg::ST_LEAF: begin
        state_nxt = leaf_changed ? mtt_pkg::ST_WALK : mtt_pkg::ST_RESP;
      end
      mtt_pkg::ST_WALK: begin
        if (parent == ROOT_ADDR) begin
          state_nxt = mtt_pkg::ST_RESP;
        end
      end
      mtt_pkg::ST_RESP: begin
        if (resp_load) begin
          state_nxt = mtt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mtt_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_nxt              = clr_r;
    cmd_nxt              = cmd_r;
    leaf_nxt             = leaf_r;
    val_nxt              = val_r;
    cand_nxt             = cand_r;
    pos_nxt              = pos_r;
    cur_val_nxt          = cur_val_r;
    cur_who_nxt          = cur_who_r;
    root_val_nxt         = root_val_r;
    root_who_nxt         = root_who_r;
    last_closed_nxt      = last_closed_r;
    live_nxt             = live_r;
    out_valid_nxt        = out_valid_r && out_stall;
    out_top_value_nxt    = out_top_value_r;
    out_top_leaf_nxt     = out_top_leaf_r;
    out_heap_empty_nxt   = out_heap_empty_r;
    out_closed_value_nxt = out_closed_value_r;
    ram_we               = 1'b0;
    ram_waddr            = pos_r;
    ram_wdata            = {1'b0, cur_who_r, cur_val_r};
    ram_raddr            = in_leaf_pos;
    left_val             = cur_val_r;
    left_who             = cur_who_r;
    right_val            = rd_val;
    right_who            = rd_who;
    new_val              = rd_val;
    new_mark             = rd_mark;

    unique case (state_r)
      mtt_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = {1'b0, {LW{1'b0}}, INF};
        clr_nxt   = clr_r + AW'(1);
      end
      mtt_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = in_cmd;
          leaf_nxt = in_leaf;
          val_nxt  = in_v;
          cand_nxt = sum_sat;
          pos_nxt  = in_leaf_pos;
        end
      end
      mtt_pkg::ST_LEAF: begin
        // Fetch the sibling while the leaf is rewritten.
        ram_raddr = pos_r ^ ROOT_ADDR;
        left_val  = cand_r;
        left_who  = leaf_r;
        right_val = rd_val;
        right_who = leaf_r;
        unique case (cmd_r)
          mtt_pkg::CMD_LOAD: begin
            new_val  = val_r;
            new_mark = 1'b0;
          end
          mtt_pkg::CMD_RELAX: begin
            new_val  = win_val;
            new_mark = 1'b0;
          end
          mtt_pkg::CMD_CLOSE: begin
            new_val  = INF;
            new_mark = 1'b1;
          end
          default: begin
            new_val  = rd_val;
            new_mark = rd_mark;
          end
        endcase
        if (leaf_changed) begin
          ram_we      = 1'b1;
          ram_waddr   = pos_r;
          ram_wdata   = {new_mark, leaf_r, new_val};
          cur_val_nxt = new_val;
          cur_who_nxt = leaf_r;
          if (cmd_r == mtt_pkg::CMD_LOAD) begin
            if (live_r != mtt_pkg::LIVE_MAX) begin
              live_nxt = live_r + mtt_pkg::LIVE_W'(1);
            end
          end else if (cmd_r == mtt_pkg::CMD_CLOSE) begin
            last_closed_nxt = rd_val;
            if (live_r != '0) begin
              live_nxt = live_r - mtt_pkg::LIVE_W'(1);
            end
          end
        end
      end
      mtt_pkg::ST_WALK: begin
        ram_raddr = parent ^ ROOT_ADDR;
        if (!pos_r[0]) begin
          left_val  = cur_val_r;
          left_who  = cur_who_r;
          right_val = rd_val;
          right_who = rd_who;
        end else begin
          left_val  = rd_val;
          left_who  = rd_who;
          right_val = cur_val_r;
          right_who = cur_who_r;
        end
        ram_we      = 1'b1;
        ram_waddr   = parent;
        ram_wdata   = {1'b0, win_who, win_val};
        cur_val_nxt = win_val;
        cur_who_nxt = win_who;
        pos_nxt     = parent;
        if (parent == ROOT_ADDR) begin
          root_val_nxt = win_val;
          root_who_nxt = win_who;
        end
      end
      mtt_pkg::ST_RESP: begin
        if (resp_load) begin
          out_valid_nxt        = 1'b1;
          out_top_value_nxt    = root_ext[PW-1:0];
          out_top_leaf_nxt     = root_who_r;
          out_heap_empty_nxt   = (live_r == '0);
          out_closed_value_nxt = closed_ext[PW-1:0];
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= mtt_pkg::ST_CLEAR;
      clr_r         <= '0;
      root_val_r    <= INF;
      root_who_r    <= '0;
      last_closed_r <= '0;
      live_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      root_val_r    <= root_val_nxt;
      root_who_r    <= root_who_nxt;
      last_closed_r <= last_closed_nxt;
      live_r        <= live_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r              <= cmd_nxt;
    leaf_r             <= leaf_nxt;
    val_r              <= val_nxt;
    cand_r             <= cand_nxt;
    pos_r              <= pos_nxt;
    cur_val_r          <= cur_val_nxt;
    cur_who_r          <= cur_who_nxt;
    out_top_value_r    <= out_top_value_nxt;
    out_top_leaf_r     <= out_top_leaf_nxt;
    out_heap_empty_r   <= out_heap_empty_nxt;
    out_closed_value_r <= out_closed_value_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_top_value    = out_top_value_r;
  assign out_top_leaf     = out_top_leaf_r;
  assign out_heap_empty   = out_heap_empty_r;
  assign out_closed_value = out_closed_value_r;

endmodule

/* hw/rtl/mtt_checker.sv */
// Port-level checks on the min tournament tree block, bound to its top level.
module mtt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [mtt_pkg::PORT_VAL_W-1:0] out_top_value,
  input logic [mtt_pkg::LEAF_W-1:0]     out_top_leaf,
  input logic                           out_heap_empty,
  input logic [mtt_pkg::PORT_VAL_W-1:0] out_closed_value
);

  // Reset starts the clearing sweep with no result pending.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block not stalled or result pending after reset");

  // One request at a time: stall right after every accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one still in flight");

  // A new result appears only out of the busy response cycle.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in flight");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable({out_top_value, out_top_leaf, out_heap_empty, out_closed_value}))
    else $error("stalled result dropped or changed");

endmodule

bind min_tournament_tree_relax_close_core mtt_checker u_mtt_checker (.*);
